// File: sv/fpe_pkg.sv
// Package for the frustum plane extractor.
// Holds widths, plane codes and the sequencer state type; no dependencies.
package fpe_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = VALUE_WIDTH + 1;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int NUM_W       = COMP_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(NUM_W + 1);

    localparam logic [2:0] PLANE_LEFT   = 3'd0;
    localparam logic [2:0] PLANE_RIGHT  = 3'd1;
    localparam logic [2:0] PLANE_TOP    = 3'd2;
    localparam logic [2:0] PLANE_BOTTOM = 3'd3;
    localparam logic [2:0] PLANE_NEAR   = 3'd4;
    localparam logic [2:0] PLANE_FAR    = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;
endpackage

// File: sv/fpe_elem_if.sv
// Channel carrying one matrix element transaction.
// Depends on fpe_pkg for the value width.
interface fpe_elem_if;
    logic                               valid;
    logic                               ready;
    logic [3:0]                         element_index;
    logic signed [fpe_pkg::VALUE_WIDTH-1:0] element_value;
    logic                               load_last;
    modport source (output valid, element_index, element_value, load_last, input ready);
    modport sink   (input valid, element_index, element_value, load_last, output ready);
endinterface

// File: sv/fpe_plane_if.sv
// Channel carrying one normalised plane transaction.
// Depends on fpe_pkg for the value width.
interface fpe_plane_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         plane_index;
    logic signed [fpe_pkg::VALUE_WIDTH-1:0] normal_x;
    logic signed [fpe_pkg::VALUE_WIDTH-1:0] normal_y;
    logic signed [fpe_pkg::VALUE_WIDTH-1:0] normal_z;
    logic signed [fpe_pkg::VALUE_WIDTH-1:0] plane_offset;
    logic                               degenerate;
    logic                               plane_last;
    modport source (output valid, plane_index, normal_x, normal_y, normal_z, plane_offset,
                    degenerate, plane_last, input ready);
    modport sink   (input valid, plane_index, normal_x, normal_y, normal_z, plane_offset,
                    degenerate, plane_last, output ready);
endinterface

// File: sv/frustum_plane_extract.sv
// Frustum plane extractor top level: matrix store, sequencer and shared bit-serial unit.
// Depends on fpe_pkg, fpe_elem_if and fpe_plane_if.
// Each element transaction is accepted while the block is idle. A transaction with load_last
// starts a run of six planes; each plane needs a load state, three 33-step shift-add
// squarings, a 33-step square root and, unless degenerate, four 49-step restoring divisions,
// all on one shared serial datapath, and then waits for its output handshake. The block
// takes no element during a run.
module frustum_plane_extract (
    input  logic        clk,
    input  logic        rst_n,
    fpe_elem_if.sink    elem,
    fpe_plane_if.source plane
);
    import fpe_pkg::*;

    state_t                  state_reg;
    logic [VALUE_WIDTH-1:0]  store_reg [16];
    logic [2:0]              plane_reg;
    logic [1:0]              k_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [COMP_W-1:0]       mag_reg [4];
    logic [3:0]              neg_reg;
    logic [SQ_W-1:0]         acc_reg;
    logic [SQ_W-1:0]         mcand_reg;
    logic [COMP_W-1:0]       mplier_reg;
    logic [COMP_W+1:0]       srem_reg;
    logic [COMP_W-1:0]       root_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [COMP_W:0]         drem_reg;
    logic [VALUE_WIDTH-1:0]  res_reg [4];
    logic                    degen_reg;

    logic signed [COMP_W-1:0] comp_next [4];
    logic [COMP_W+1:0]       sq_shift_next;
    logic [COMP_W+1:0]       trial_next;
    logic [COMP_W:0]         drem_shift_next;
    logic                    dgeq_next;
    logic [NUM_W-1:0]        quo_next;
    logic [VALUE_WIDTH-1:0]  sat_next;

    localparam logic [NUM_W-1:0] SAT_POS = NUM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

    assign elem.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            logic signed [COMP_W-1:0] c3;
            logic signed [COMP_W-1:0] c0;
            logic signed [COMP_W-1:0] c1;
            logic signed [COMP_W-1:0] c2;
            c3 = COMP_W'($signed(store_reg[r*4+3]));
            c0 = COMP_W'($signed(store_reg[r*4+0]));
            c1 = COMP_W'($signed(store_reg[r*4+1]));
            c2 = COMP_W'($signed(store_reg[r*4+2]));
            case (plane_reg)
                PLANE_LEFT:   comp_next[r] = c3 + c0;
                PLANE_RIGHT:  comp_next[r] = c3 - c0;
                PLANE_TOP:    comp_next[r] = c3 - c1;
                PLANE_BOTTOM: comp_next[r] = c3 + c1;
                PLANE_NEAR:   comp_next[r] = c2;
                default:      comp_next[r] = c3 - c2;
            endcase
        end
    end

    assign sq_shift_next   = {srem_reg[COMP_W-1:0], acc_reg[SQ_W-1:SQ_W-2]};
    assign trial_next      = {root_reg, 2'b01};
    assign drem_shift_next = {drem_reg[COMP_W-1:0], num_reg[NUM_W-1]};
    assign dgeq_next       = drem_shift_next >= {1'b0, root_reg};
    assign quo_next        = {quo_reg[NUM_W-2:0], dgeq_next};

    always_comb
    begin
        if (!neg_reg[k_reg])
        begin
            if (quo_next > SAT_POS)
                sat_next = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            else
                sat_next = quo_next[VALUE_WIDTH-1:0];
        end
        else
        begin
            if (quo_next > SAT_POS + NUM_W'(1))
                sat_next = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            else
                sat_next = VALUE_WIDTH'(0) - quo_next[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= 3'd0;
            k_reg     <= 2'd0;
            cnt_reg   <= '0;
            for (int i = 0; i < 16; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (elem.valid)
                    begin
                        store_reg[elem.element_index] <= elem.element_value;
                        if (elem.load_last)
                        begin
                            plane_reg <= PLANE_LEFT;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        neg_reg[r] <= comp_next[r][COMP_W-1];
                        mag_reg[r] <= comp_next[r][COMP_W-1] ? COMP_W'(0) - comp_next[r]
                                                            : comp_next[r];
                    end
                    acc_reg    <= '0;
                    mcand_reg  <= SQ_W'(comp_next[0][COMP_W-1] ? COMP_W'(0) - comp_next[0]
                                                               : comp_next[0]);
                    mplier_reg <= comp_next[0][COMP_W-1] ? COMP_W'(0) - comp_next[0]
                                                        : comp_next[0];
                    k_reg      <= 2'd0;
                    cnt_reg    <= '0;
                    state_reg  <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[SQ_W-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == CNT_W'(COMP_W - 1))
                    begin
                        cnt_reg <= '0;
                        if (k_reg == 2'd2)
                        begin
                            srem_reg  <= '0;
                            root_reg  <= '0;
                            state_reg <= ST_SQRT;
                        end
                        else
                        begin
                            k_reg      <= k_reg + 2'd1;
                            mcand_reg  <= SQ_W'(mag_reg[k_reg + 2'd1]);
                            mplier_reg <= mag_reg[k_reg + 2'd1];
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_SQRT:
                begin
                    acc_reg <= {acc_reg[SQ_W-3:0], 2'b00};
                    if (sq_shift_next >= trial_next)
                    begin
                        srem_reg <= sq_shift_next - trial_next;
                        root_reg <= {root_reg[COMP_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= sq_shift_next;
                        root_reg <= {root_reg[COMP_W-2:0], 1'b0};
                    end
                    if (cnt_reg == CNT_W'(COMP_W - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_DIV;
                        k_reg     <= 2'd0;
                        num_reg   <= {mag_reg[0], {FRAC_BITS{1'b0}}};
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        degen_reg <= 1'b0;
                        if ((root_reg == '0) && !(sq_shift_next >= trial_next))
                        begin
                            degen_reg <= 1'b1;
                            for (int i = 0; i < 4; i++)
                                res_reg[i] <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_DIV:
                begin
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    drem_reg <= dgeq_next ? drem_shift_next - {1'b0, root_reg}
                                          : drem_shift_next;
                    quo_reg  <= quo_next;
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        cnt_reg        <= '0;
                        res_reg[k_reg] <= sat_next;
                        drem_reg       <= '0;
                        quo_reg        <= '0;
                        if (k_reg == 2'd3)
                            state_reg <= ST_OUT;
                        else
                        begin
                            k_reg   <= k_reg + 2'd1;
                            num_reg <= {mag_reg[k_reg + 2'd1], {FRAC_BITS{1'b0}}};
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_OUT:
                begin
                    if (plane.ready)
                    begin
                        if (plane_reg == PLANE_FAR)
                        begin
                            plane_reg <= PLANE_LEFT;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            plane_reg <= plane_reg + 3'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign plane.valid        = (state_reg == ST_OUT);
    assign plane.plane_index  = plane_reg;
    assign plane.normal_x     = res_reg[0];
    assign plane.normal_y     = res_reg[1];
    assign plane.normal_z     = res_reg[2];
    assign plane.plane_offset = res_reg[3];
    assign plane.degenerate   = degen_reg;
    assign plane.plane_last   = (plane_reg == PLANE_FAR);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(elem.ready && plane.valid))
        else $error("Element accepted while a plane is pending.");
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane.valid |-> (plane_reg <= PLANE_FAR))
        else $error("Plane index out of range.");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (plane.valid && plane.degenerate) |-> (plane.normal_x == '0 && plane.normal_y == '0
            && plane.normal_z == '0 && plane.plane_offset == '0))
        else $error("Degenerate plane carries non-zero components.");
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (plane.valid && plane.ready && plane.plane_last) |=> (state_reg == ST_IDLE))
        else $error("Run did not end after the far plane.");
endmodule

// File: verif/frustum_plane_extract_test.sv
// Self-checking testbench for frustum_plane_extract: loads matrices element by element and
// checks every normalised plane against an independent fixed-point predictor.
// Depends on fpe_pkg, fpe_elem_if and fpe_plane_if.
class plane_scoreboard;
    typedef struct {
        logic [2:0]  idx;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] off;
        logic        degen;
        logic        last;
    } plane_t;

    logic signed [31:0] matrix [16];
    plane_t             pending [$];
    int                 errors;

    function new();
        errors = 0;
        foreach (matrix[i])
        begin
            matrix[i] = '0;
        end
    endfunction

    function logic [31:0] scaled_quotient(logic signed [33:0] x, logic [63:0] len);
        logic [127:0] num;
        logic [127:0] q;
        logic [33:0]  mag;
        logic signed [63:0] v;
        mag = x < 0 ? -x : x;
        num = {94'b0, mag} << fpe_pkg::FRAC_BITS;
        q = num / len;
        if (x >= 0)
        begin
            v = (q > 128'h7FFFFFFF) ? 64'sh7FFFFFFF : $signed({32'b0, q[31:0]});
        end
        else
        begin
            v = (q > 128'h80000000) ? -64'sh80000000 : -$signed({32'b0, q[31:0]});
        end
        return v[31:0];
    endfunction

    function logic [63:0] root_floor(logic [127:0] sq);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'b0, t} * {64'b0, t} <= sq)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    function void note_element(logic [3:0] idx, logic signed [31:0] value, logic last_flag);
        logic signed [33:0] comp [4];
        logic signed [33:0] c3;
        logic signed [33:0] other;
        logic [127:0]       sq;
        logic [63:0]        len;
        logic [33:0]        m;
        plane_t             p;
        matrix[idx] = value;
        if (!last_flag)
        begin
            return;
        end
        for (int pl = 0; pl < 6; pl++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                c3 = matrix[r * 4 + 3];
                case (pl)
                    fpe_pkg::PLANE_LEFT:   other = matrix[r * 4];
                    fpe_pkg::PLANE_RIGHT:  other = -$signed(34'(matrix[r * 4]));
                    fpe_pkg::PLANE_TOP:    other = -$signed(34'(matrix[r * 4 + 1]));
                    fpe_pkg::PLANE_BOTTOM: other = matrix[r * 4 + 1];
                    fpe_pkg::PLANE_NEAR:   other = matrix[r * 4 + 2];
                    default:               other = -$signed(34'(matrix[r * 4 + 2]));
                endcase
                comp[r] = (pl == fpe_pkg::PLANE_NEAR) ? other : c3 + other;
            end
            sq = '0;
            for (int k = 0; k < 3; k++)
            begin
                m = comp[k] < 0 ? -comp[k] : comp[k];
                sq += {94'b0, m} * {94'b0, m};
            end
            len = root_floor(sq);
            p.idx = 3'(pl);
            p.last = (pl == fpe_pkg::PLANE_FAR);
            p.degen = (len == 0);
            if (len == 0)
            begin
                p.nx = '0;
                p.ny = '0;
                p.nz = '0;
                p.off = '0;
            end
            else
            begin
                p.nx = scaled_quotient(comp[0], len);
                p.ny = scaled_quotient(comp[1], len);
                p.nz = scaled_quotient(comp[2], len);
                p.off = scaled_quotient(comp[3], len);
            end
            pending.push_back(p);
        end
    endfunction

    function void check_plane(plane_t got);
        plane_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected plane transaction, index %0d", $time, got.idx);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.idx !== want.idx || got.nx !== want.nx || got.ny !== want.ny
            || got.nz !== want.nz || got.off !== want.off || got.degen !== want.degen
            || got.last !== want.last)
        begin
            $display("%0t: plane mismatch expected idx=%0d n=(%h %h %h) d=%h dg=%b l=%b",
                     $time, want.idx, want.nx, want.ny, want.nz, want.off, want.degen,
                     want.last);
            $display("%0t:                actual idx=%0d n=(%h %h %h) d=%h dg=%b l=%b",
                     $time, got.idx, got.nx, got.ny, got.nz, got.off, got.degen, got.last);
            errors++;
        end
    endfunction
endclass

module frustum_plane_extract_test;
    import fpe_pkg::*;

    logic clk;
    logic rst_n;
    fpe_elem_if  elem();
    fpe_plane_if plane();

    plane_scoreboard board;
    bit              calm;
    bit              hold_long;
    int              idle_cycles;
    int              sent;

    frustum_plane_extract dut (
        .clk   (clk),
        .rst_n (rst_n),
        .elem  (elem.sink),
        .plane (plane.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sh0;
            3:       return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            4:       return $signed($urandom_range(0, 32'hFF));
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_element(logic [3:0] idx, logic signed [31:0] value, logic last_flag);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            elem.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem.valid         <= 1'b1;
        elem.element_index <= idx;
        elem.element_value <= value;
        elem.load_last     <= last_flag;
        @(posedge clk);
        while (!elem.ready)
        begin
            @(posedge clk);
        end
        board.note_element(idx, value, last_flag);
        sent++;
    endtask

    task automatic wait_drained();
        elem.valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic load_matrix(int fill);
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(0, 99) < fill)
            begin
                send_element(4'(i), pick_value(), 1'b0);
            end
        end
        send_element(4'($urandom_range(0, 15)), pick_value(), 1'b1);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        calm = 1'b0;
        hold_long = 1'b0;
        sent = 0;
        elem.valid = 1'b0;
        elem.element_index = '0;
        elem.element_value = '0;
        elem.load_last = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset store gives all degenerate planes.
        send_element(4'd0, 32'sh0, 1'b1);
        // Identity matrix.
        for (int i = 0; i < 16; i++)
        begin
            send_element(4'(i), (i % 5 == 0) ? 32'sh10000 : 32'sh0, i == 15);
        end
        // Extreme element values at both ends of the signed range.
        send_element(4'd3, 32'sh7FFFFFFF, 1'b0);
        send_element(4'd15, 32'sh80000000, 1'b0);
        send_element(4'd11, 32'sh7FFFFFFF, 1'b0);
        send_element(4'd0, 32'sh1, 1'b0);
        send_element(4'd10, 32'sh80000000, 1'b0);
        send_element(4'd7, 32'shFFFFFFFF, 1'b1);
        wait_drained();

        hold_long = 1'b1;
        for (int n = 0; n < 3; n++)
        begin
            send_element(4'($urandom_range(0, 15)), pick_value(), 1'b1);
        end
        wait_drained();

        while (sent < 150)
        begin
            load_matrix($urandom_range(0, 2) == 0 ? 100 : 20);
            if (sent > 120)
            begin
                calm = 1'b1;
            end
        end
        wait_drained();
        repeat (2500) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        int gap;
        plane.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                plane.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 12);
                plane.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                plane.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && plane.valid && plane.ready)
        begin
            board.check_plane('{plane.plane_index, plane.normal_x, plane.normal_y,
                                plane.normal_z, plane.plane_offset, plane.degenerate,
                                plane.plane_last});
        end
    end

    always @(posedge clk)
    begin
        if ((elem.valid && elem.ready) || (plane.valid && plane.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end
endmodule

// File: sim.f
sv/fpe_pkg.sv
sv/fpe_elem_if.sv
sv/fpe_plane_if.sv
sv/frustum_plane_extract.sv
verif/frustum_plane_extract_test.sv
